// File: src/cpp_pkg.sv
package cpp_pkg;

    // Defaults for the size parameters of the top level.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Field widths.
    localparam int PIX_W      = 8;
    localparam int CFG_W      = 11;
    localparam int IDX_W      = 10;
    localparam int SUM_W      = 18;
    localparam int WIDE_W     = SUM_W + 1;
    localparam int CFG_ADDR_W = 1;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FIELD_W = IDX_W + SUM_W + SUM_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // Full-scale pixel; the accumulated quantity is this minus the pixel.
    localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;

    // Column sums saturate at the top of their range.
    localparam logic [SUM_W-1:0] SUM_LIMIT = '1;

    // Register indexes on the configuration channel.
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Reset value of both size registers.
    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

    // Position of a pixel within the image.
    typedef struct packed {
        logic first_row;
        logic last_row;
        logic last_col;
    } scan_pos_t;

    // Occupancy of the accumulate stage.
    typedef struct packed {
        logic busy;
        logic advance;
    } stage_stat_t;

    // A size of zero counts as one; sizes above the limit saturate.
    function automatic int clamp_size(int v, int limit);
        if (v == 0) begin
            return 1;
        end
        if (v > limit) begin
            return limit;
        end
        return v;
    endfunction

endpackage

// File: src/cpp_col_mem.sv
module cpp_col_mem
    import cpp_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_WIDTH,
    parameter int ADDR_W = 10,
    parameter int DATA_W = SUM_W
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/cpp_scan_ctrl.sv
module cpp_scan_ctrl
    import cpp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COL_W      = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_write,
    input  logic [CFG_ADDR_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  pix_accept,
    output logic [COL_W-1:0]      pix_col,
    output scan_pos_t             pix_pos
);

    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);

    logic [WCNT_W-1:0] width_reg,  width_next;
    logic [HCNT_W-1:0] height_reg, height_next;
    logic [COL_W-1:0]  col_reg,    col_next;
    logic [ROW_W-1:0]  row_reg,    row_next;

    logic last_col;
    logic last_row;

    // Size registers hold the clamped sizes.
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write) begin
            case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    width_next = WCNT_W'(clamp_size(int'(cfg_data), MAX_WIDTH));
                end
                REG_IMAGE_HEIGHT: begin
                    height_next = HCNT_W'(clamp_size(int'(cfg_data), MAX_HEIGHT));
                end
                default: begin
                end
            endcase
        end
    end

    // Position of the current pixel.
    assign last_col = (WCNT_W'(col_reg) + WCNT_W'(1)) >= width_reg;
    assign last_row = (HCNT_W'(row_reg) + HCNT_W'(1)) >= height_reg;

    assign pix_col            = col_reg;
    assign pix_pos.first_row  = (row_reg == '0);
    assign pix_pos.last_row   = last_row;
    assign pix_pos.last_col   = last_col;

    // Raster counters step on each pixel transfer.
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WCNT_W'(clamp_size(int'(CFG_SIZE_RESET), MAX_WIDTH));
            height_reg <= HCNT_W'(clamp_size(int'(CFG_SIZE_RESET), MAX_HEIGHT));
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

// File: src/cpp_accum.sv
module cpp_accum
    import cpp_pkg::*;
#(
    parameter int COL_W = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Pixel entering the stage
    input  logic                   in_accept,
    input  logic [PIX_W-1:0]       in_inv,
    input  logic [COL_W-1:0]       in_col,
    input  scan_pos_t              in_pos,
    output logic                   in_ready,
    // Column sum memory
    input  logic [SUM_W-1:0]       rd_data,
    output logic                   wr_en,
    output logic [COL_W-1:0]       wr_addr,
    output logic [SUM_W-1:0]       wr_data,
    // Result register
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [IDX_W-1:0]       out_index,
    output logic [SUM_W-1:0]       out_sum,
    output logic [SUM_W-1:0]       out_max,
    output logic                   out_last,
    output stage_stat_t            stat
);

    logic              p1_valid_reg, p1_valid_next;
    logic [PIX_W-1:0]  p1_inv_reg;
    logic [COL_W-1:0]  p1_col_reg;
    scan_pos_t         p1_pos_reg;

    logic              fwd_valid_reg;
    logic [COL_W-1:0]  fwd_addr_reg;
    logic [SUM_W-1:0]  fwd_data_reg;

    logic [SUM_W-1:0]  max_reg, max_next;

    logic              m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]  m_index_reg;
    logic [SUM_W-1:0]  m_sum_reg;
    logic [SUM_W-1:0]  m_max_reg;
    logic              m_last_reg;

    logic              emit;
    logic              advance;
    logic [SUM_W-1:0]  base;
    logic [WIDE_W-1:0] wide;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  max_sel;

    // The stage moves on unless it holds a result and the output is full.
    assign emit     = p1_pos_reg.last_row;
    assign advance  = p1_valid_reg && (!emit || !m_valid_reg || out_ready);
    assign in_ready = !p1_valid_reg || advance;

    // A write in the same cycle as this entry's read is not in the read data.
    assign base = (fwd_valid_reg && (fwd_addr_reg == p1_col_reg)) ? fwd_data_reg : rd_data;
    assign wide = WIDE_W'(base) + WIDE_W'(p1_inv_reg);

    // The first row starts the sum; later rows add with saturation.
    always_comb begin
        if (p1_pos_reg.first_row) begin
            sum = SUM_W'(p1_inv_reg);
        end else if (wide > WIDE_W'(SUM_LIMIT)) begin
            sum = SUM_LIMIT;
        end else begin
            sum = wide[SUM_W-1:0];
        end
    end

    // Column zero restarts the maximum.
    assign max_sel = ((p1_col_reg == '0) || (sum > max_reg)) ? sum : max_reg;

    always_comb begin
        max_next = max_reg;
        if (advance && emit) begin
            max_next = p1_pos_reg.last_col ? '0 : max_sel;
        end
    end

    assign wr_en   = advance;
    assign wr_addr = p1_col_reg;
    assign wr_data = sum;

    // Stage occupancy.
    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (in_accept) begin
            p1_valid_next = 1'b1;
        end else if (advance) begin
            p1_valid_next = 1'b0;
        end
    end

    // Result register empties on a transfer and fills from the stage.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance && emit) begin
            m_valid_next = 1'b1;
        end else if (out_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            max_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            p1_valid_reg  <= p1_valid_next;
            max_reg       <= max_next;
            m_valid_reg   <= m_valid_next;
            if (wr_en) begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            p1_inv_reg <= in_inv;
            p1_col_reg <= in_col;
            p1_pos_reg <= in_pos;
        end
        if (wr_en) begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
        if (advance && emit) begin
            m_index_reg <= IDX_W'(p1_col_reg);
            m_sum_reg   <= sum;
            m_max_reg   <= max_sel;
            m_last_reg  <= p1_pos_reg.last_col;
        end
    end

    assign out_valid    = m_valid_reg;
    assign out_index    = m_index_reg;
    assign out_sum      = m_sum_reg;
    assign out_max      = m_max_reg;
    assign out_last     = m_last_reg;
    assign stat.busy    = p1_valid_reg;
    assign stat.advance = advance;

endmodule

// File: src/column_projection_profile_unit.sv
// Column projection profile. Pixels stream in row-major order, one per transfer, and
// the block accumulates 255 minus each pixel into a per-column sum held in a RAM of
// MAX_WIDTH entries (first row writes, later rows read, add and write back). Every pixel
// of the last row yields one result: column index, finished column sum, the running
// maximum over the finished columns of this image, and tlast on the final column.
// The sustained rate is one pixel per clock while no result is held up: the RAM read is
// issued on the input transfer and the add and write-back happen in the accumulate stage
// after it, with a bypass of the write from the cycle of the read, so a one-column image
// also runs at full rate. A result passes from the accumulate stage into an output
// register, so input keeps flowing while one result waits; input stalls only when that
// register is full and another result is due. No clearing pass is needed after reset.
// The user must write size registers only with the stream idle; no logic enforces it.
module column_projection_profile_unit
    import cpp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_ADDR_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    // Pixel input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] pixel_value
    // Result output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [9:0] column_index, [27:10] column_sum,
                                              // [45:28] profile_max, [47:46] zero
    output logic                   m_tlast    // last_column
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic              pix_accept;
    logic [COL_W-1:0]  pix_col;
    scan_pos_t         pix_pos;
    logic [PIX_W-1:0]  pix_inv;

    logic [SUM_W-1:0]  rd_data;
    logic              wr_en;
    logic [COL_W-1:0]  wr_addr;
    logic [SUM_W-1:0]  wr_data;

    logic [IDX_W-1:0]  out_index;
    logic [SUM_W-1:0]  out_sum;
    logic [SUM_W-1:0]  out_max;
    stage_stat_t       stat;

    assign cfg_ready  = 1'b1;
    assign pix_accept = s_tvalid && s_tready;
    assign pix_inv    = PIX_FULL - s_tdata[PIX_W-1:0];

    cpp_scan_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix_accept (pix_accept),
        .pix_col    (pix_col),
        .pix_pos    (pix_pos)
    );

    cpp_col_mem #(
        .DEPTH   (MAX_WIDTH),
        .ADDR_W  (COL_W),
        .DATA_W  (SUM_W)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (pix_accept),
        .rd_addr (pix_col),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    cpp_accum #(
        .COL_W     (COL_W)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (pix_accept),
        .in_inv    (pix_inv),
        .in_col    (pix_col),
        .in_pos    (pix_pos),
        .in_ready  (s_tready),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (out_index),
        .out_sum   (out_sum),
        .out_max   (out_max),
        .out_last  (m_tlast),
        .stat      (stat)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_max, out_sum, out_index};

    // The reported maximum always covers the reported column.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_max >= out_sum))
        else $error("profile_max below column_sum");

    // A new pixel enters an occupied stage only when that stage drains in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pix_accept && stat.busy) |-> stat.advance)
        else $error("pixel accepted over a stalled accumulate stage");

    // Reset leaves the pipeline empty.
    assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !stat.busy))
        else $error("pipeline not empty after reset");

endmodule
